@@ hdl/status_led_priority_sequencer_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Status LED sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef STATUS_LED_PRIORITY_SEQUENCER_UNIT_MACROS_SVH
`define STATUS_LED_PRIORITY_SEQUENCER_UNIT_MACROS_SVH

// Checked while out of reset
`define SLPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define SLPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/slps_pkg.sv @@
// ---------------------------------------------------------------------------
// Status LED sequencer package
// Widths, timing constants, register codes and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package slps_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned LenW     = 11;
  localparam int unsigned PctW     = 7;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [TimeW-1:0]  HbPeriodMs = 32'd7000;
  localparam logic [TimeW-1:0]  HbBlinkMs  = 32'd60;
  localparam logic [LenW-1:0]   PulseMinMs = 11'd20;
  localparam logic [LenW-1:0]   PulseMaxMs = 11'd2000;
  localparam logic [PctW-1:0]   PctMax     = 7'd100;
  localparam logic [LevelW-1:0] LevelFull  = 8'd255;

  // Reset values of the configuration registers
  localparam logic [LenW-1:0]   PulseLenRst   = 11'd250;
  localparam logic [LevelW-1:0] PulseByteRst  = 8'd255;  // 100 %
  localparam logic [LevelW-1:0] HbByteRst     = 8'd25;   // 10 %

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgPulseLen   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPulseLevel = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHbLevel    = 2'd2;

  // 2^22 / 100 rounded up, exact for dividends up to 25500
  localparam logic [15:0] Div100Recip = 16'd41944;

  typedef struct packed {
    logic [LenW-1:0]   pulse_len;
    logic [LevelW-1:0] pulse_byte;
    logic [LevelW-1:0] hb_byte;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic             link_up;
    logic             camera_ok;
    logic             capture_event;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] red_level;
    logic [LevelW-1:0] green_level;
    logic [LevelW-1:0] blue_level;
  } rgb_t;

  // Percent (already clamped to 100) to drive byte: p*255/100
  function automatic logic [LevelW-1:0] pct_to_byte(input logic [PctW-1:0] p);
    logic [14:0] scaled;
    logic [30:0] prod;
    scaled = {p, 8'd0} - {8'd0, p};
    prod   = {16'd0, scaled} * {15'd0, Div100Recip};
    return prod[29:22];
  endfunction

endpackage

@@ hdl/slps_if.sv @@
// ---------------------------------------------------------------------------
// Status LED sequencer channels
// Valid/ready channels for the tick items and the color items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slps_in_if import slps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] time_ms;
  logic             link_up;
  logic             camera_ok;
  logic             capture_event;

  modport source (output valid, time_ms, link_up, camera_ok, capture_event, input ready);
  modport sink   (input valid, time_ms, link_up, camera_ok, capture_event, output ready);
endinterface

interface slps_out_if import slps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] red_level;
  logic [LevelW-1:0] green_level;
  logic [LevelW-1:0] blue_level;

  modport source (output valid, red_level, green_level, blue_level, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, output ready);
endinterface

@@ hdl/slps_cfg.sv @@
// ---------------------------------------------------------------------------
// Status LED sequencer configuration registers
// Saturating register writes; brightness is kept as a ready drive byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slps_cfg import slps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t            cfg_q, cfg_d;
  logic [LenW-1:0] len_in;
  logic [PctW-1:0] pct_in;
  logic [PctW-1:0] pct_sat;

  // Clamp incoming values to their ranges
  always_comb begin
    len_in  = cfg_data_i[LenW-1:0];
    pct_in  = cfg_data_i[PctW-1:0];
    pct_sat = (pct_in > PctMax) ? PctMax : pct_in;
    cfg_d   = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPulseLen: begin
          if (len_in < PulseMinMs) begin
            cfg_d.pulse_len = PulseMinMs;
          end else if (len_in > PulseMaxMs) begin
            cfg_d.pulse_len = PulseMaxMs;
          end else begin
            cfg_d.pulse_len = len_in;
          end
        end
        CfgPulseLevel: cfg_d.pulse_byte = pct_to_byte(pct_sat);
        CfgHbLevel:    cfg_d.hb_byte    = pct_to_byte(pct_sat);
        default:       cfg_d = cfg_q;   // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_len  <= PulseLenRst;
      cfg_q.pulse_byte <= PulseByteRst;
      cfg_q.hb_byte    <= HbByteRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/status_led_priority_sequencer_unit.sv @@
// ---------------------------------------------------------------------------
// Status LED priority sequencer
// Picks one RGB color per tick item: link down red, capture pulse green,
// camera heartbeat blue, otherwise off.
// ---------------------------------------------------------------------------
// Pipeline registers: input reg, result reg; an accepted item moves from the input
//   register into the result register once the result register is free.
// Throughput: one item per cycle while the output is not stalled; the timer state
//   updates as an item moves from the input register into the result register.
// Reset: all control and timer state cleared, configuration at its defaults.
`timescale 1ns / 1ps
`include "status_led_priority_sequencer_unit_macros.svh"

module status_led_priority_sequencer_unit import slps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  slps_in_if.sink             in_i,
  slps_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;

  logic     s1_valid_q;
  in_item_t s1_q;
  logic     out_valid_q;
  rgb_t     out_q, rgb_d;

  logic             pending_q, pending_d;
  logic [TimeW-1:0] pulse_end_q, pulse_end_d;
  logic [TimeW-1:0] blink_end_q, blink_end_d;
  logic [TimeW-1:0] next_blink_q, next_blink_d;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  logic             pend;
  logic [TimeW-1:0] now;
  logic [TimeW-1:0] now_period;
  logic [TimeW-1:0] pulse_end;
  logic [TimeW-1:0] nb;
  logic [TimeW-1:0] be;

  slps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: result register frees up when empty or being taken
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  // Priority decision and timer update for the item in the input register
  always_comb begin
    now        = s1_q.time_ms;
    now_period = now + HbPeriodMs;
    pend       = pending_q || s1_q.capture_event;
    pulse_end  = pend ? (now + {21'd0, cfg.pulse_len}) : pulse_end_q;
    nb         = (next_blink_q == '0) ? now_period : next_blink_q;
    be         = blink_end_q;
    if (now >= nb && be == '0) begin
      be = now + HbBlinkMs;
      nb = now_period;
    end

    pending_d    = pending_q;
    pulse_end_d  = pulse_end_q;
    blink_end_d  = blink_end_q;
    next_blink_d = next_blink_q;
    rgb_d        = '0;

    if (!s1_q.link_up) begin
      // link down: solid red, capture stays pending
      pending_d       = pend;
      rgb_d.red_level = LevelFull;
    end else begin
      pending_d   = 1'b0;
      pulse_end_d = pulse_end;
      if (now < pulse_end) begin
        rgb_d.green_level = cfg.pulse_byte;
      end else if (s1_q.camera_ok) begin
        next_blink_d = nb;
        blink_end_d  = be;
        if (be != '0 && now < be) begin
          rgb_d.blue_level = cfg.hb_byte;
        end else if (be != '0) begin
          blink_end_d = '0;  // blink over
        end
      end
    end
  end

  // Control and timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pending_q    <= 1'b0;
      pulse_end_q  <= '0;
      blink_end_q  <= '0;
      next_blink_q <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        pending_q    <= pending_d;
        pulse_end_q  <= pulse_end_d;
        blink_end_q  <= blink_end_d;
        next_blink_q <= next_blink_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.time_ms       <= in_i.time_ms;
      s1_q.link_up       <= in_i.link_up;
      s1_q.camera_ok     <= in_i.camera_ok;
      s1_q.capture_event <= in_i.capture_event;
    end
    if (s1_fire) begin
      out_q <= rgb_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.red_level   = out_q.red_level;
  assign out_o.green_level = out_q.green_level;
  assign out_o.blue_level  = out_q.blue_level;

  // Checks
  `SLPS_ASSERT(a_ready_only_blocked_when_full, !in_i.ready |-> s1_valid_q, "ready low with empty input register")
  `SLPS_ASSERT(a_held_item_stays, s1_valid_q && !out_free |=> s1_valid_q, "stalled item lost from input register")
  `SLPS_ASSERT(a_link_down_freezes_timers, s1_fire && !s1_q.link_up |=> $stable(pulse_end_q) && $stable(blink_end_q) && $stable(next_blink_q), "timers changed while link down")
  `SLPS_ASSERT(a_link_up_clears_pending, s1_fire && s1_q.link_up |=> !pending_q, "pending capture not consumed")
  `SLPS_ASSERT(a_single_color, out_valid_q && out_q.red_level != '0 |-> out_q.green_level == '0 && out_q.blue_level == '0, "red mixed with another channel")
  `SLPS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q && !s1_valid_q, "pipeline valid during reset")

endmodule
